>>> sv/quadratic_root_solver_core_defines.svh
// Assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define QRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("qrs check");
`define QRS_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("qrs check");
`else
`define QRS_ASSERT(label, clk, rst_n, prop)
`define QRS_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> sv/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
    localparam int OUT_BITS = 40;
    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_ZERO_QUAD = 2'd2
    } status_t;
    typedef struct packed {
        logic    valid;
        status_t status;
    } qrs_ctl_t;
endpackage
`default_nettype wire

>>> sv/quadratic_root_solver_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_root_solver_core_defines.svh"
// Pipeline from input transfer to output transfer: products, discriminant,
// COEF_BITS+FRAC_BITS+1 sqrt steps, numerator signs, COEF_BITS+FRAC_BITS+3 divide steps,
// output register.
// Throughput: one transfer per cycle; the whole pipe holds while a valid result is stalled.
// Reset: rst_n clears all valid bits asynchronously; no transfer is in flight after it.
module quadratic_root_solver_core import qrs_pkg::*; #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [15:0]   coef_quad,
    input  wire logic signed [15:0]   coef_lin,
    input  wire logic signed [15:0]   coef_const,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [OUT_BITS-1:0] root_plus,
    output logic signed [OUT_BITS-1:0] root_minus,
    output logic [1:0]                solve_status
);
    localparam int DB  = 2 * COEF_BITS + 2;       // discriminant width, signed
    localparam int SQS = DB / 2 + FRAC_BITS;      // sqrt steps = root bits
    localparam int SQW = SQS + 1;
    localparam int DW  = 2 * SQS;                 // padded radicand width
    localparam int NW  = COEF_BITS + FRAC_BITS + 3 > SQW + 1 ?
                         COEF_BITS + FRAC_BITS + 3 : SQW + 1;
    localparam int DV  = COEF_BITS + 2;           // |2a|
    localparam int DEPTH = DB / 2 + FRAC_BITS;

    logic adv;
    assign adv      = !out_stall || !out_valid;
    assign in_stall = !adv;

    // Stage 1: products
    logic s1_v_reg;
    logic signed [COEF_BITS-1:0] a1_reg, b1_reg;
    logic signed [2*COEF_BITS-1:0] bb1_reg, ac1_reg;
    logic signed [COEF_BITS-1:0] a_in, b_in, c_in;
    assign a_in = coef_quad[COEF_BITS-1:0];
    assign b_in = coef_lin[COEF_BITS-1:0];
    assign c_in = coef_const[COEF_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg  <= a_in;
            b1_reg  <= b_in;
            bb1_reg <= b_in * b_in;
            ac1_reg <= a_in * c_in;
        end
    end

    // Stage 2: discriminant, status
    logic s2_v_reg;
    qrs_ctl_t ctl2_reg;
    logic signed [COEF_BITS-1:0] a2_reg, b2_reg;
    logic [DB-1:0] disc2_reg;
    logic signed [DB-1:0] disc_c;
    assign disc_c = DB'(bb1_reg) - (DB'(ac1_reg) <<< 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            ctl2_reg.valid <= s1_v_reg;
            priority if (a1_reg == '0)
                ctl2_reg.status <= ST_ZERO_QUAD;
            else if (disc_c[DB-1])
                ctl2_reg.status <= ST_NEG_DISC;
            else
                ctl2_reg.status <= ST_OK;
            disc2_reg <= disc_c[DB-1] ? '0 : disc_c;
        end
    end

    // Sqrt pipeline; a, b, status ride alongside
    logic          sq_v   [0:SQS];
    logic [DW-1:0] sq_rad [0:SQS];
    logic [SQW-1:0] sq_root [0:SQS];
    logic [SQW+1:0] sq_rem [0:SQS];
    logic signed [COEF_BITS-1:0] sq_a [0:SQS];
    logic signed [COEF_BITS-1:0] sq_b [0:SQS];
    status_t sq_st [0:SQS];

    assign sq_v[0]    = s2_v_reg;
    assign sq_rad[0]  = {disc2_reg, {(DW-DB){1'b0}}};
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_a[0]    = a2_reg;
    assign sq_b[0]    = b2_reg;
    assign sq_st[0]   = ctl2_reg.status;

    for (genvar i = 0; i < SQS; i++)
    begin : g_sq
        qrs_sqrt_stage #(.RW(SQW), .DW(DW)) u_st (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(sq_v[i]), .in_rad(sq_rad[i]),
            .in_root(sq_root[i]), .in_rem(sq_rem[i]),
            .out_valid(sq_v[i+1]), .out_rad(sq_rad[i+1]),
            .out_root(sq_root[i+1]), .out_rem(sq_rem[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_a[i+1]  <= sq_a[i];
                sq_b[i+1]  <= sq_b[i];
                sq_st[i+1] <= sq_st[i];
            end
        end
    end

    // Stage 3: magnitudes and signs for the two numerators
    logic s3_v_reg;
    status_t st3_reg;
    logic [NW-1:0] n0_3_reg, n1_3_reg;
    logic neg0_3_reg, neg1_3_reg;
    logic [DV-1:0] den3_reg;
    logic signed [NW:0] base_c, num0_c, num1_c;
    logic signed [DV:0] den_c;
    assign base_c = -((NW+1)'(sq_b[SQS]) <<< FRAC_BITS);
    assign num0_c = base_c + (NW+1)'(sq_root[SQS]);
    assign num1_c = base_c - (NW+1)'(sq_root[SQS]);
    assign den_c  = (DV+1)'(sq_a[SQS]) <<< 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= sq_v[SQS];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st3_reg    <= sq_st[SQS];
            n0_3_reg   <= NW'(num0_c[NW] ? -num0_c : num0_c);
            n1_3_reg   <= NW'(num1_c[NW] ? -num1_c : num1_c);
            den3_reg   <= DV'(den_c[DV] ? -den_c : den_c);
            neg0_3_reg <= num0_c[NW] ^ den_c[DV];
            neg1_3_reg <= num1_c[NW] ^ den_c[DV];
        end
    end

    // Divider pipeline
    logic          dv_v   [0:NW];
    logic [NW-1:0] dv_n0  [0:NW];
    logic [DV-1:0] dv_r0  [0:NW];
    logic [NW-1:0] dv_n1  [0:NW];
    logic [DV-1:0] dv_r1  [0:NW];
    logic [DV-1:0] dv_den [0:NW];
    logic          dv_g0  [0:NW];
    logic          dv_g1  [0:NW];
    status_t       dv_st  [0:NW];

    assign dv_v[0]   = s3_v_reg;
    assign dv_n0[0]  = n0_3_reg;
    assign dv_n1[0]  = n1_3_reg;
    assign dv_r0[0]  = '0;
    assign dv_r1[0]  = '0;
    assign dv_den[0] = den3_reg;
    assign dv_g0[0]  = neg0_3_reg;
    assign dv_g1[0]  = neg1_3_reg;
    assign dv_st[0]  = st3_reg;

    for (genvar j = 0; j < NW; j++)
    begin : g_dv
        qrs_div_stage #(.NW(NW), .DV(DV)) u_dv (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(dv_v[j]), .den(dv_den[j]),
            .in_n0(dv_n0[j]), .in_r0(dv_r0[j]),
            .in_n1(dv_n1[j]), .in_r1(dv_r1[j]),
            .out_valid(dv_v[j+1]),
            .out_n0(dv_n0[j+1]), .out_r0(dv_r0[j+1]),
            .out_n1(dv_n1[j+1]), .out_r1(dv_r1[j+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_den[j+1] <= dv_den[j];
                dv_g0[j+1]  <= dv_g0[j];
                dv_g1[j+1]  <= dv_g1[j];
                dv_st[j+1]  <= dv_st[j];
            end
        end
    end

    // Output: sign, saturate, force zero on flagged items
    localparam logic [63:0] MAXP = (64'd1 << (OUT_BITS - 1)) - 64'd1;
    localparam logic [63:0] MAXN = 64'd1 << (OUT_BITS - 1);
    logic out_v_reg;
    logic signed [OUT_BITS-1:0] rp_reg, rm_reg;
    status_t st_reg;
    logic signed [OUT_BITS-1:0] rp_c, rm_c;

    always_comb
    begin
        if (dv_g0[NW])
            rp_c = (64'(dv_n0[NW]) > MAXN) ? OUT_BITS'(MAXN) : OUT_BITS'(-dv_n0[NW]);
        else
            rp_c = (64'(dv_n0[NW]) > MAXP) ? OUT_BITS'(MAXP) : OUT_BITS'(dv_n0[NW]);
        if (dv_g1[NW])
            rm_c = (64'(dv_n1[NW]) > MAXN) ? OUT_BITS'(MAXN) : OUT_BITS'(-dv_n1[NW]);
        else
            rm_c = (64'(dv_n1[NW]) > MAXP) ? OUT_BITS'(MAXP) : OUT_BITS'(dv_n1[NW]);
        if (dv_st[NW] != ST_OK)
        begin
            rp_c = '0;
            rm_c = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= dv_v[NW];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg <= rp_c;
            rm_reg <= rm_c;
            st_reg <= dv_st[NW];
        end
    end

    assign out_valid    = out_v_reg;
    assign root_plus    = rp_reg;
    assign root_minus   = rm_reg;
    assign solve_status = st_reg;

    `QRS_ASSERT(a_hold_out, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(root_plus))
    `QRS_ASSERT(a_stall_src, clk, rst_n, in_stall |-> out_valid && out_stall)
    `QRS_ASSERT(a_flag_zero, clk, rst_n, out_valid && solve_status != ST_OK |-> root_plus == '0 && root_minus == '0)
    `QRS_ASSERT_NR(a_rst_clear, clk, !rst_n |=> !out_valid || !rst_n)
    `QRS_ASSERT(a_depth, clk, rst_n, adv && s2_v_reg |-> DEPTH == SQS)
endmodule
`default_nettype wire

>>> sv/qrs_sqrt_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring square root step per call, registered when the pipe advances.
module qrs_sqrt_stage import qrs_pkg::*; #(
    parameter int RW = 32,
    parameter int DW = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rad,
    input  wire logic [RW-1:0] in_root,
    input  wire logic [RW+1:0] in_rem,
    output logic               out_valid,
    output logic [DW-1:0]      out_rad,
    output logic [RW-1:0]      out_root,
    output logic [RW+1:0]      out_rem
);
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW-1:0] root_next;
    logic [RW+1:0] rem_next;

    always_comb
    begin
        rem_sh = {in_rem[RW-1:0], in_rad[DW-1 -: 2]};
        trial  = {in_root, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {in_root[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {in_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rad  <= {in_rad[DW-3:0], 2'b00};
            out_root <= root_next;
            out_rem  <= rem_next;
        end
    end
endmodule
`default_nettype wire

>>> sv/qrs_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring division step for two quotients sharing a divisor.
module qrs_div_stage import qrs_pkg::*; #(
    parameter int NW = 48,
    parameter int DV = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [DV-1:0] den,
    input  wire logic [NW-1:0] in_n0,
    input  wire logic [DV-1:0] in_r0,
    input  wire logic [NW-1:0] in_n1,
    input  wire logic [DV-1:0] in_r1,
    output logic               out_valid,
    output logic [NW-1:0]      out_n0,
    output logic [DV-1:0]      out_r0,
    output logic [NW-1:0]      out_n1,
    output logic [DV-1:0]      out_r1
);
    logic [DV:0] s0, s1;
    logic [NW-1:0] n0_next, n1_next;
    logic [DV-1:0] r0_next, r1_next;

    // numerator shifts left; quotient bits fill in from the bottom
    always_comb
    begin
        s0 = {in_r0, in_n0[NW-1]};
        s1 = {in_r1, in_n1[NW-1]};
        if (s0 >= {1'b0, den})
        begin
            r0_next = DV'(s0 - {1'b0, den});
            n0_next = {in_n0[NW-2:0], 1'b1};
        end
        else
        begin
            r0_next = s0[DV-1:0];
            n0_next = {in_n0[NW-2:0], 1'b0};
        end
        if (s1 >= {1'b0, den})
        begin
            r1_next = DV'(s1 - {1'b0, den});
            n1_next = {in_n1[NW-2:0], 1'b1};
        end
        else
        begin
            r1_next = s1[DV-1:0];
            n1_next = {in_n1[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_n0 <= n0_next;
            out_r0 <= r0_next;
            out_n1 <= n1_next;
            out_r1 <= r1_next;
        end
    end
endmodule
`default_nettype wire
